FILE: src/crcpec_pkg.sv
// ----------------------------------------------------------------------------
// crcpec_pkg
// shared types and constants of the programmable crc encode/check core
// ----------------------------------------------------------------------------
package crcpec_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;
    localparam int GEN_POLY_W = 33;
    localparam int GEN_LEN_W  = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

    // register reset values
    localparam logic [GEN_POLY_W-1:0] GEN_POLY_RST = 33'd3;
    localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = 6'd2;

    // mode codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    // stream data widths
    localparam int TDATA_W = 8;

    // remainder bit operation
    typedef logic [1:0] t_r_op;
    localparam t_r_op R_HOLD  = 2'd0;
    localparam t_r_op R_SHIFT = 2'd1;
    localparam t_r_op R_CLEAR = 2'd2;

    // augmented remainder bit operation
    typedef logic [2:0] t_a_op;
    localparam t_a_op A_HOLD  = 3'd0;
    localparam t_a_op A_SHIFT = 3'd1;
    localparam t_a_op A_LOAD  = 3'd2;
    localparam t_a_op A_EMIT  = 3'd3;
    localparam t_a_op A_CLEAR = 3'd4;

    // control broadcast to every cell of the row
    typedef struct packed {
        t_r_op r_op;
        t_a_op a_op;
        logic  din;
        logic  fb_r;
        logic  fb_a;
    } t_cell_ctrl;

endpackage

FILE: src/crcpec_cell.sv
// ----------------------------------------------------------------------------
// crcpec_cell
// one bit of the division row: plain remainder bit and augmented remainder bit
// ----------------------------------------------------------------------------
module crcpec_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crcpec_pkg::t_cell_ctrl i_ctrl,
    input  logic                  i_en,
    input  logic                  i_g,
    input  logic                  i_r_prev,
    input  logic                  i_a_prev,
    output logic                  o_r,
    output logic                  o_a,
    output logic                  o_r_shift
);

    logic r_r;
    logic r_a;
    logic n_r;
    logic n_a;

    // shifted remainder bit, masked to the active degree
    assign o_r_shift = i_en & (i_r_prev ^ (i_ctrl.fb_r & i_g));

    // next state of both bits
    always_comb begin
        case (i_ctrl.r_op)
            crcpec_pkg::R_HOLD:  n_r = r_r;
            crcpec_pkg::R_SHIFT: n_r = o_r_shift;
            crcpec_pkg::R_CLEAR: n_r = 1'b0;
            default:             n_r = r_r;
        endcase
        case (i_ctrl.a_op)
            crcpec_pkg::A_HOLD:  n_a = r_a;
            crcpec_pkg::A_SHIFT: n_a = i_en & (i_a_prev ^ (i_ctrl.fb_a & i_g));
            crcpec_pkg::A_LOAD:  n_a = i_en & r_r;
            crcpec_pkg::A_EMIT:  n_a = i_en & i_a_prev;
            crcpec_pkg::A_CLEAR: n_a = 1'b0;
            default:             n_a = r_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r <= 1'b0;
            r_a <= 1'b0;
        end else begin
            r_r <= n_r;
            r_a <= n_a;
        end
    end

    assign o_r = r_r;
    assign o_a = r_a;

endmodule

FILE: src/crcpec_cfg.sv
// ----------------------------------------------------------------------------
// crcpec_cfg
// configuration registers and derived generator information
// ----------------------------------------------------------------------------
module crcpec_cfg #(
    parameter int MAX_GEN_BITS = 33,
    parameter int N  = MAX_GEN_BITS - 1,
    parameter int GW = $clog2(MAX_GEN_BITS),
    parameter int IW = (N > 1) ? $clog2(N) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [crcpec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crcpec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [GW-1:0]                     o_d,
    output logic [IW-1:0]                     o_dm1,
    output logic [N-1:0]                      o_g,
    output logic [N-1:0]                      o_en,
    output logic                              o_gen_ok,
    output logic                              o_mode
);

    localparam int LW = $clog2(MAX_GEN_BITS + 1);

    logic [crcpec_pkg::GEN_POLY_W-1:0] r_gen_poly;
    logic [crcpec_pkg::GEN_LEN_W-1:0]  r_gen_len;
    logic                              r_mode;

    logic [LW-1:0]           w_len;
    logic [MAX_GEN_BITS-1:0] w_gext;
    logic [MAX_GEN_BITS-1:0] w_lmask;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_poly <= crcpec_pkg::GEN_POLY_RST;
            r_gen_len  <= crcpec_pkg::GEN_LEN_RST;
            r_mode     <= crcpec_pkg::MODE_ENCODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crcpec_pkg::CFG_GEN_POLY: r_gen_poly <= i_cfg_data;
                crcpec_pkg::CFG_GEN_LEN:  r_gen_len  <= i_cfg_data[crcpec_pkg::GEN_LEN_W-1:0];
                crcpec_pkg::CFG_MODE:     r_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the generator length to the supported range
    always_comb begin
        if (int'(r_gen_len) < 2) begin
            w_len = LW'(2);
        end else if (int'(r_gen_len) > MAX_GEN_BITS) begin
            w_len = LW'(MAX_GEN_BITS);
        end else begin
            w_len = LW'(r_gen_len);
        end
    end

    assign w_gext = MAX_GEN_BITS'(r_gen_poly);
    assign o_d    = GW'(w_len - LW'(1));
    assign o_dm1  = IW'(w_len - LW'(2));
    assign o_g    = w_gext[N-1:0];
    assign o_mode = r_mode;

    // per-bit masks for the generator length and the degree
    always_comb begin
        for (int i = 0; i < MAX_GEN_BITS; i++) begin
            w_lmask[i] = (i < int'(w_len));
        end
        for (int i = 0; i < N; i++) begin
            o_en[i] = (i < int'(o_d));
        end
    end

    // both end coefficients set and even weight
    assign o_gen_ok = w_gext[0] & w_gext[o_d] & ~(^(w_gext & w_lmask));

endmodule

FILE: src/crc_programmable_encode_check_core.sv
// ----------------------------------------------------------------------------
// crc_programmable_encode_check_core
// serial crc encoder and checker with a programmable generator
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one message bit per beat (tdata[0]), tlast marks the final
//   bit. m_axis returns results: tdata = {gen_ok, check_ok, out_bit} from bit 0,
//   tlast marks the final result of a message. the cfg channel writes
//   gen_poly (0), gen_len (1) and mode (2); it is always ready and must only be
//   used while no beat is in flight.
// order and throughput
//   a result appears in the output register the cycle after its input beat;
//   in check mode only the final bit gives one. one bit per cycle is taken
//   while the output register is free or drained. in encode mode the final
//   bit is followed by d remainder beats (d = degree), one per cycle while the
//   output register is free or drained, with the input held off meanwhile.
//   after a configuration write mid-message, the cell row first runs d zero shifts and one load step.
// reset and stall
//   reset clears the remainder row and restores gen_poly 3, gen_len 2, encode.
//   when m_axis_tready is low the output register holds its beat and
//   s_axis_tready drops until that beat is taken.
// ----------------------------------------------------------------------------
module crc_programmable_encode_check_core #(
    parameter int MAX_GEN_BITS = 33
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input bits
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [crcpec_pkg::TDATA_W-1:0]    s_axis_tdata,   // [0] msg_bit
    input  logic                              s_axis_tlast,   // last_bit
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [crcpec_pkg::TDATA_W-1:0]    m_axis_tdata,   // [0] out_bit, [1] check_ok, [2] gen_ok
    output logic                              m_axis_tlast,   // end_of_run
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crcpec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crcpec_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int N  = MAX_GEN_BITS - 1;
    localparam int GW = $clog2(MAX_GEN_BITS);
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    // sequencer states
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [GW-1:0] w_d;
    logic [IW-1:0] w_dm1;
    logic [N-1:0]  w_g;
    logic [N-1:0]  w_en;
    logic          w_gok;
    logic          w_mode;

    logic [N-1:0]  w_r;
    logic [N-1:0]  w_a;
    logic [N-1:0]  w_rs;

    crcpec_pkg::t_cell_ctrl w_ctrl;
    crcpec_pkg::t_r_op      w_rop;
    crcpec_pkg::t_a_op      w_aop;
    logic                   w_din;

    logic [1:0]    r_state, n_state;
    logic [GW-1:0] r_cnt, n_cnt;
    logic          r_in_msg, n_in_msg;
    logic          r_stale, n_stale;
    logic          r_ov, n_ov;
    logic          r_obit, n_obit;
    logic          r_ochk, n_ochk;
    logic          r_ogok, n_ogok;
    logic          r_olast, n_olast;

    logic          w_slot;
    logic          w_acc;
    logic          w_bit;

    // configuration registers
    crcpec_cfg #(
        .MAX_GEN_BITS (MAX_GEN_BITS),
        .N            (N),
        .GW           (GW),
        .IW           (IW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_d         (w_d),
        .o_dm1       (w_dm1),
        .o_g         (w_g),
        .o_en        (w_en),
        .o_gen_ok    (w_gok),
        .o_mode      (w_mode)
    );

    assign o_cfg_ready = 1'b1;

    // row of division cells, bit 0 takes the incoming bit
    assign w_ctrl = '{r_op: w_rop, a_op: w_aop, din: w_din,
                      fb_r: w_r[w_dm1], fb_a: w_a[w_dm1] ^ w_din};

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic w_rp;
        logic w_ap;
        if (i == 0) begin : g_first
            assign w_rp = w_din;
            assign w_ap = 1'b0;
        end else begin : g_next
            assign w_rp = w_r[i-1];
            assign w_ap = w_a[i-1];
        end
        crcpec_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_en      (w_en[i]),
            .i_g       (w_g[i]),
            .i_r_prev  (w_rp),
            .i_a_prev  (w_ap),
            .o_r       (w_r[i]),
            .o_a       (w_a[i]),
            .o_r_shift (w_rs[i])
        );
    end

    // handshake
    assign w_slot        = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == ST_RUN) && w_slot;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_bit         = s_axis_tdata[0];

    // sequencer and output register control
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_in_msg = r_in_msg;
        n_stale  = r_stale;
        n_ov     = r_ov && !m_axis_tready;
        n_obit   = r_obit;
        n_ochk   = r_ochk;
        n_ogok   = r_ogok;
        n_olast  = r_olast;
        w_rop    = crcpec_pkg::R_HOLD;
        w_aop    = crcpec_pkg::A_HOLD;
        w_din    = 1'b0;

        // configuration written inside a message: augmented row no longer valid
        if (i_cfg_valid && r_in_msg) begin
            n_stale = 1'b1;
        end

        case (r_state)
            ST_RUN: begin
                if (w_acc) begin
                    w_din = w_bit;
                    w_rop = crcpec_pkg::R_SHIFT;
                    w_aop = crcpec_pkg::A_SHIFT;
                    if (w_mode == crcpec_pkg::MODE_ENCODE) begin
                        n_ov    = 1'b1;
                        n_obit  = w_bit;
                        n_ochk  = 1'b0;
                        n_ogok  = w_gok;
                        n_olast = 1'b0;
                    end
                    if (s_axis_tlast) begin
                        n_in_msg = 1'b0;
                        n_stale  = 1'b0;
                        n_cnt    = w_d;
                        if (w_mode == crcpec_pkg::MODE_ENCODE) begin
                            if (r_stale) begin
                                w_aop   = crcpec_pkg::A_HOLD;
                                n_state = ST_ZERO;
                            end else begin
                                w_rop   = crcpec_pkg::R_CLEAR;
                                n_state = ST_EMIT;
                            end
                        end else begin
                            n_ov    = 1'b1;
                            n_obit  = 1'b0;
                            n_ochk  = ~(|w_rs);
                            n_ogok  = w_gok;
                            n_olast = 1'b1;
                            w_rop   = crcpec_pkg::R_CLEAR;
                            w_aop   = crcpec_pkg::A_CLEAR;
                        end
                    end else begin
                        n_in_msg = 1'b1;
                    end
                end
            end
            ST_ZERO: begin
                // augment the plain remainder with zero bits
                w_rop = crcpec_pkg::R_SHIFT;
                n_cnt = r_cnt - GW'(1);
                if (r_cnt == GW'(1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                w_rop   = crcpec_pkg::R_CLEAR;
                w_aop   = crcpec_pkg::A_LOAD;
                n_cnt   = w_d;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // remainder bits out, most significant first
                if (w_slot) begin
                    n_ov    = 1'b1;
                    n_obit  = w_a[w_dm1];
                    n_ochk  = 1'b0;
                    n_ogok  = w_gok;
                    n_olast = (r_cnt == GW'(1));
                    w_aop   = crcpec_pkg::A_EMIT;
                    n_cnt   = r_cnt - GW'(1);
                    if (r_cnt == GW'(1)) begin
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_cnt    <= '0;
            r_in_msg <= 1'b0;
            r_stale  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_in_msg <= n_in_msg;
            r_stale  <= n_stale;
            r_ov     <= n_ov;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_obit  <= n_obit;
        r_ochk  <= n_ochk;
        r_ogok  <= n_ogok;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(crcpec_pkg::TDATA_W-3){1'b0}}, r_ogok, r_ochk, r_obit};
    assign m_axis_tlast  = r_olast;

    // input is held off during the remainder tail
    a_no_accept_in_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !s_axis_tready)
        else $error("input accepted outside run state");

    // plain remainder is cleared before the tail is shifted out
    a_rem_clear_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (w_r == '0))
        else $error("remainder not cleared during emission");

    // tail counter never underflows inside the tail
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) || (r_state == ST_ZERO)) |-> (r_cnt != '0))
        else $error("tail counter at zero inside tail");

    // the final remainder beat closes the tail
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && w_slot && (r_cnt == GW'(1))) |=>
            ((r_state == ST_RUN) && r_ov && r_olast))
        else $error("tail did not end with a last beat");

    // stale flag only lives inside a message
    a_stale_in_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stale |-> r_in_msg)
        else $error("stale flag outside a message");

endmodule
